/* rtl/cid_pkg.sv */
// ----------------------------------------------------------------------------
// Compressed instruction decoder package
// Instruction codes, ALU operation codes and the per-instruction control row
// shared by the decoder and its checker.
// ----------------------------------------------------------------------------
package cid_pkg;

  localparam int WordWidth = 16;
  localparam int RegWidth  = 3;
  localparam int ImmWidth  = 9;
  localparam int CodeWidth = 4;
  localparam int AluWidth  = 3;

  // Internal instruction codes.
  localparam logic [CodeWidth-1:0] INST_LW   = 4'd0;
  localparam logic [CodeWidth-1:0] INST_SW   = 4'd1;
  localparam logic [CodeWidth-1:0] INST_ADD  = 4'd2;
  localparam logic [CodeWidth-1:0] INST_ADDI = 4'd3;
  localparam logic [CodeWidth-1:0] INST_AND  = 4'd4;
  localparam logic [CodeWidth-1:0] INST_ANDI = 4'd5;
  localparam logic [CodeWidth-1:0] INST_OR   = 4'd6;
  localparam logic [CodeWidth-1:0] INST_XOR  = 4'd7;
  localparam logic [CodeWidth-1:0] INST_SRAI = 4'd8;
  localparam logic [CodeWidth-1:0] INST_SLLI = 4'd9;
  localparam logic [CodeWidth-1:0] INST_BEQZ = 4'd10;
  localparam logic [CodeWidth-1:0] INST_BNEZ = 4'd11;

  // ALU operation codes.
  localparam logic [AluWidth-1:0] ALU_ADD  = 3'd0;
  localparam logic [AluWidth-1:0] ALU_AND  = 3'd2;
  localparam logic [AluWidth-1:0] ALU_OR   = 3'd3;
  localparam logic [AluWidth-1:0] ALU_XOR  = 3'd4;
  localparam logic [AluWidth-1:0] ALU_SLLI = 3'd5;
  localparam logic [AluWidth-1:0] ALU_BEQZ = 3'd6;
  localparam logic [AluWidth-1:0] ALU_BNEZ = 3'd7;

  // Major opcode values of bits 15:13.
  localparam logic [2:0] FUNC_ARITH_IMM = 3'd0;
  localparam logic [2:0] FUNC_LOAD      = 3'd2;
  localparam logic [2:0] FUNC_ALU       = 3'd4;
  localparam logic [2:0] FUNC_STORE_BR  = 3'd6;
  localparam logic [2:0] FUNC_BNEZ      = 3'd7;

  // Values of the low opcode bits 1:0.
  localparam logic [1:0] QUAD0 = 2'd0;
  localparam logic [1:0] QUAD1 = 2'd1;
  localparam logic [1:0] QUAD2 = 2'd2;
  localparam logic [1:0] QUAD3 = 2'd3;

  // Sub-selector of the ALU group in bits 11:10.
  localparam logic [1:0] SUB_NONE      = 2'd0;
  localparam logic [1:0] SUB_SHIFT_ADD = 2'd1;
  localparam logic [1:0] SUB_ANDI      = 2'd2;
  localparam logic [1:0] SUB_REG       = 2'd3;

  // Register-register logic operation in bits 6:5.
  localparam logic [1:0] SEL_NONE = 2'd0;
  localparam logic [1:0] SEL_XOR  = 2'd1;
  localparam logic [1:0] SEL_OR   = 2'd2;
  localparam logic [1:0] SEL_AND  = 2'd3;

  typedef struct packed {
    logic [AluWidth-1:0] alu_op;
    logic                reg_write_en;
    logic                reg_dst_sel;
    logic                alu_b_imm;
    logic                mem_write_en;
    logic                mem_to_reg_sel;
    logic                reg_src_sel;
  } ctl_t;

  function automatic ctl_t ctl_lookup(input logic [CodeWidth-1:0] code);
    ctl_t c;
    unique case (code)
      INST_LW:   c = '{ALU_ADD,  1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
      INST_SW:   c = '{ALU_ADD,  1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
      INST_ADD:  c = '{ALU_ADD,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
      INST_ADDI: c = '{ALU_ADD,  1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
      INST_AND:  c = '{ALU_AND,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
      INST_ANDI: c = '{ALU_AND,  1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
      INST_OR:   c = '{ALU_OR,   1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
      INST_XOR:  c = '{ALU_XOR,  1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
      INST_SRAI: c = '{ALU_XOR,  1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
      INST_SLLI: c = '{ALU_SLLI, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
      INST_BEQZ: c = '{ALU_BEQZ, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
      INST_BNEZ: c = '{ALU_BNEZ, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
      default:   c = '{ALU_ADD,  1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
    endcase
    return c;
  endfunction

endpackage

/* rtl/compressed_instruction_decoder_unit.sv */
// ----------------------------------------------------------------------------
// Compressed instruction decoder unit
// Decodes one 16-bit compressed instruction per cycle into register fields,
// an immediate, an instruction code, an ALU operation and control signals.
// ----------------------------------------------------------------------------
// Usage:
//   An instruction is taken on a rising edge where start is high and busy is
//   low. busy is high only while rst is asserted, so outside reset a new
//   instruction may be given on every cycle.
//   The decoded item passes through two registers: the input register takes
//   it, then the decode logic writes the result register. done is high for
//   a single cycle while the result ports hold the item.
//   Throughput is one instruction per cycle; the decode is a single pass of
//   field selection and a small control lookup between the two registers.
//   There is no back pressure: the receiver must take each result in the
//   cycle it is shown.
//   Reset (synchronous, active high) empties both registers, so no done
//   strobe follows an instruction that was in flight when reset came.
// ----------------------------------------------------------------------------
module compressed_instruction_decoder_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [cid_pkg::WordWidth-1:0]     instruction_word,
  output logic                              done,
  output logic [cid_pkg::RegWidth-1:0]      src_reg_a,
  output logic [cid_pkg::RegWidth-1:0]      src_reg_b,
  output logic [cid_pkg::RegWidth-1:0]      dest_reg,
  output logic [cid_pkg::ImmWidth-1:0]      imm_value,
  output logic [cid_pkg::CodeWidth-1:0]     inst_code,
  output logic [cid_pkg::AluWidth-1:0]      alu_op,
  output logic                              reg_write_en,
  output logic                              reg_dst_sel,
  output logic                              alu_b_imm,
  output logic                              mem_write_en,
  output logic                              mem_to_reg_sel,
  output logic                              reg_src_sel
);

  logic                          in_valid;
  logic [cid_pkg::WordWidth-1:0] word;

  logic [cid_pkg::RegWidth-1:0]  a_next, b_next, d_next;
  logic [cid_pkg::ImmWidth-1:0]  imm_next;
  logic [cid_pkg::CodeWidth-1:0] code_next;
  cid_pkg::ctl_t                 ctl_next;

  logic [2:0]                    func;
  logic [1:0]                    quad, wsel, ssel;
  logic [cid_pkg::RegWidth-1:0]  hi, lo;
  logic [cid_pkg::ImmWidth-1:0]  mem_imm, br_off, nz_imm, andi_imm;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    word <= instruction_word;
  end

  assign func = word[15:13];
  assign quad = word[1:0];
  assign wsel = word[11:10];
  assign ssel = word[6:5];
  assign hi   = word[9:7];
  assign lo   = word[4:2];

  assign mem_imm  = {2'b00, word[5], word[12], word[11:10], word[6], 2'b00};
  assign br_off   = {word[12], word[12], word[6:5], word[2], word[11:10], word[4:3]};
  assign nz_imm   = {3'b000, word[12], word[6:5], lo};
  assign andi_imm = {2'b00, word[12], 1'b0, word[6:5], lo};

  always_comb begin
    a_next    = '0;
    b_next    = '0;
    d_next    = '0;
    imm_next  = '0;
    code_next = cid_pkg::INST_LW;
    unique case (func)
      cid_pkg::FUNC_LOAD: begin
        a_next   = hi;
        d_next   = lo;
        imm_next = mem_imm;
      end
      cid_pkg::FUNC_STORE_BR: begin
        if (quad == cid_pkg::QUAD0) begin
          a_next    = hi;
          b_next    = lo;
          imm_next  = mem_imm;
          code_next = cid_pkg::INST_SW;
        end else if (quad == cid_pkg::QUAD1) begin
          a_next    = hi;
          imm_next  = br_off;
          code_next = cid_pkg::INST_BEQZ;
        end
      end
      cid_pkg::FUNC_BNEZ: begin
        a_next    = hi;
        imm_next  = br_off;
        code_next = cid_pkg::INST_BNEZ;
      end
      cid_pkg::FUNC_ALU: begin
        if (wsel == cid_pkg::SUB_SHIFT_ADD) begin
          if (quad == cid_pkg::QUAD2) begin
            d_next    = hi;
            b_next    = lo;
            code_next = cid_pkg::INST_ADD;
          end else if (quad == cid_pkg::QUAD1) begin
            a_next    = hi;
            d_next    = hi;
            imm_next  = nz_imm;
            code_next = cid_pkg::INST_SRAI;
          end
        end else if (wsel == cid_pkg::SUB_REG) begin
          // The funct2 field picks the register-register logic operation.
          if (ssel != cid_pkg::SEL_NONE) begin
            a_next = hi;
            d_next = hi;
            b_next = lo;
            unique case (ssel)
              cid_pkg::SEL_AND: code_next = cid_pkg::INST_AND;
              cid_pkg::SEL_OR:  code_next = cid_pkg::INST_OR;
              default:          code_next = cid_pkg::INST_XOR;
            endcase
          end
        end else if (wsel == cid_pkg::SUB_ANDI) begin
          a_next    = hi;
          d_next    = hi;
          imm_next  = andi_imm;
          code_next = cid_pkg::INST_ANDI;
        end
      end
      cid_pkg::FUNC_ARITH_IMM: begin
        if (quad == cid_pkg::QUAD1) begin
          a_next    = hi;
          d_next    = hi;
          imm_next  = nz_imm;
          code_next = cid_pkg::INST_ADDI;
        end else if (quad == cid_pkg::QUAD2) begin
          d_next    = hi;
          imm_next  = nz_imm;
          code_next = cid_pkg::INST_SLLI;
        end
      end
      default: begin
      end
    endcase
    ctl_next = cid_pkg::ctl_lookup(code_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    src_reg_a      <= a_next;
    src_reg_b      <= b_next;
    dest_reg       <= d_next;
    imm_value      <= imm_next;
    inst_code      <= code_next;
    alu_op         <= ctl_next.alu_op;
    reg_write_en   <= ctl_next.reg_write_en;
    reg_dst_sel    <= ctl_next.reg_dst_sel;
    alu_b_imm      <= ctl_next.alu_b_imm;
    mem_write_en   <= ctl_next.mem_write_en;
    mem_to_reg_sel <= ctl_next.mem_to_reg_sel;
    reg_src_sel    <= ctl_next.reg_src_sel;
  end

endmodule

/* rtl/cid_checker.sv */
// ----------------------------------------------------------------------------
// Compressed instruction decoder checker
// Port-level assertions on strobe timing and decoded result consistency.
// ----------------------------------------------------------------------------
module cid_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [cid_pkg::RegWidth-1:0]  src_reg_b,
  input logic [cid_pkg::RegWidth-1:0]  dest_reg,
  input logic [cid_pkg::CodeWidth-1:0] inst_code,
  input logic                          reg_write_en,
  input logic                          mem_write_en
);

  // Every taken item comes out with a done strobe, after the input and result registers.
  a_done_after_take: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("taken item produced no done strobe");

  // No done strobe without a matching taken item.
  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("done strobe without a taken item");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (inst_code <= cid_pkg::INST_BNEZ))
    else $error("instruction code out of range");

  a_store_ctl: assert property (@(posedge clk) disable iff (rst)
    (done && inst_code == cid_pkg::INST_SW) |-> (mem_write_en && !reg_write_en))
    else $error("store word with wrong control signals");

  a_branch_regs: assert property (@(posedge clk) disable iff (rst)
    (done && (inst_code == cid_pkg::INST_BEQZ || inst_code == cid_pkg::INST_BNEZ))
      |-> (dest_reg == '0 && src_reg_b == '0 && !reg_write_en))
    else $error("branch decoded with destination or second source");

endmodule

bind compressed_instruction_decoder_unit cid_checker u_cid_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .src_reg_b    (src_reg_b),
  .dest_reg     (dest_reg),
  .inst_code    (inst_code),
  .reg_write_en (reg_write_en),
  .mem_write_en (mem_write_en)
);
